// ===== design/bdd_pkg.sv =====
// shared constants, stencil coefficient table and lookup for the backward difference differentiator
package bdd_pkg;

	localparam int MAX_POINTS = 10;
	localparam int HIST_DEPTH = MAX_POINTS - 1;
	localparam int COEF_W     = 19;
	localparam int SUM_GROW   = 21;
	localparam int SCALE_W    = 32;
	localparam int OUT_W      = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_ORDER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_ORDER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = 2'd2;

	// [derivative-1][error order-1][tap], newest sample at tap 0
	localparam int COEF_TAB [4][6][MAX_POINTS] = '{
		'{
			'{1, -1, 0, 0, 0, 0, 0, 0, 0, 0},
			'{3, -4, 1, 0, 0, 0, 0, 0, 0, 0},
			'{11, -18, 9, -2, 0, 0, 0, 0, 0, 0},
			'{25, -48, 36, -16, 3, 0, 0, 0, 0, 0},
			'{137, -300, 300, -200, 75, -12, 0, 0, 0, 0},
			'{147, -360, 450, -400, 225, -72, 10, 0, 0, 0}
		},
		'{
			'{1, -2, 1, 0, 0, 0, 0, 0, 0, 0},
			'{2, -5, 4, -1, 0, 0, 0, 0, 0, 0},
			'{35, -104, 114, -56, 11, 0, 0, 0, 0, 0},
			'{45, -154, 214, -156, 61, -10, 0, 0, 0, 0},
			'{812, -3132, 5265, -5080, 2970, -972, 137, 0, 0, 0},
			'{938, -4014, 7911, -9490, 7380, -3618, 1019, -126, 0, 0}
		},
		'{
			'{1, -3, 3, -1, 0, 0, 0, 0, 0, 0},
			'{5, -18, 24, -14, 3, 0, 0, 0, 0, 0},
			'{17, -71, 118, -98, 41, -7, 0, 0, 0, 0},
			'{49, -232, 461, -496, 307, -104, 15, 0, 0, 0},
			'{967, -5104, 11787, -15560, 12725, -6432, 1849, -232, 0, 0},
			'{2403, -13960, 36706, -57384, 58280, -39128, 16830, -4216, 469, 0}
		},
		'{
			'{1, -4, 6, -4, 1, 0, 0, 0, 0, 0},
			'{3, -14, 26, -24, 11, -2, 0, 0, 0, 0},
			'{35, -186, 411, -484, 321, -114, 17, 0, 0, 0},
			'{56, -333, 852, -1219, 1056, -555, 164, -21, 0, 0},
			'{3207, -21056, 61156, -102912, 109930, -76352, 33636, -8576, 967, 0},
			'{4275, -30668, 99604, -192624, 244498, -210920, 123348, -47024, 10579, -1068}
		}
	};

	function automatic logic signed [COEF_W-1:0] bdd_coef(input logic [1:0] d,
		input logic [2:0] e, input logic [3:0] k);
		return COEF_W'(COEF_TAB[d][e][k]);
	endfunction

endpackage

// ===== design/bdd_cell.sv =====
// one stencil cell: holds a history sample and forms its coefficient product
module bdd_cell import bdd_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  shift_en,
	input  logic                                  load_en,
	input  logic signed [COEF_W-1:0]              coef,
	input  logic signed [SAMPLE_BITS-1:0]         x_in,
	output logic signed [SAMPLE_BITS-1:0]         x_out,
	output logic signed [SAMPLE_BITS+COEF_W-1:0]  prod
);

	localparam int PROD_W = SAMPLE_BITS + COEF_W;

	logic signed [SAMPLE_BITS-1:0] tap_q;
	logic signed [PROD_W-1:0]      prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift_en) begin
			tap_q <= x_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			prod_s1 <= PROD_W'(x_in) * PROD_W'(coef);
		end
	end

	assign x_out = tap_q;
	assign prod  = prod_s1;

endmodule

// ===== design/bdd_sum.sv =====
// registered adder tree over the cell products
module bdd_sum import bdd_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                   clk,
	input  logic [2:0]                             en,
	input  logic signed [SAMPLE_BITS+COEF_W-1:0]   prod [MAX_POINTS],
	output logic signed [SAMPLE_BITS+SUM_GROW-1:0] sum
);

	localparam int SUM_W = SAMPLE_BITS + SUM_GROW;
	localparam int PAIRS = MAX_POINTS / 2;

	logic signed [SUM_W-1:0] pair_s2 [PAIRS];
	logic signed [SUM_W-1:0] part_s3 [2];
	logic signed [SUM_W-1:0] sum_s4;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < PAIRS; j++) begin
				pair_s2[j] <= SUM_W'(prod[2*j]) + SUM_W'(prod[2*j+1]);
			end
		end
		if (en[1]) begin
			part_s3[0] <= pair_s2[0] + pair_s2[1] + pair_s2[2];
			part_s3[1] <= pair_s2[3] + pair_s2[4];
		end
		if (en[2]) begin
			sum_s4 <= part_s3[0] + part_s3[1];
		end
	end

	assign sum = sum_s4;

endmodule

// ===== design/bdd_scale.sv =====
// q16.16 scaling with round half away from zero and 48-bit saturation
module bdd_scale import bdd_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                   clk,
	input  logic [3:0]                             en,
	input  logic signed [SAMPLE_BITS+SUM_GROW-1:0] sum,
	input  logic [SCALE_W-1:0]                     scale,
	output logic [OUT_W-1:0]                       deriv
);

	localparam int SUM_W = SAMPLE_BITS + SUM_GROW;
	localparam int HI_W  = (SUM_W > 32) ? SUM_W - 32 : 1;
	localparam int EXT_W = 32 + HI_W;
	localparam int R_W   = OUT_W + 1;

	logic                 neg_s5, neg_s6, neg_s7;
	logic [SUM_W-1:0]     mag_s5;
	logic [EXT_W-1:0]     mag_ext;
	logic [63:0]          lo_s6;
	logic [HI_W+31:0]     hi_s6;
	logic                 big_s7;
	logic [R_W-1:0]       r_s7;
	logic [R_W-1:0]       lim;
	logic [R_W-1:0]       clip;
	logic [OUT_W-1:0]     deriv_s8;

	assign mag_ext = EXT_W'(mag_s5);

	// saturation limit depends on sign: 2^47 below zero, 2^47-1 above
	assign lim  = neg_s7 ? (R_W'(1) << (OUT_W - 1)) : ((R_W'(1) << (OUT_W - 1)) - R_W'(1));
	assign clip = (big_s7 || (r_s7 > lim)) ? lim : r_s7;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s5 <= sum[SUM_W-1];
			mag_s5 <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		end
		if (en[1]) begin
			neg_s6 <= neg_s5;
			lo_s6  <= 64'(mag_ext[31:0]) * 64'(scale);
			hi_s6  <= (HI_W+32)'(mag_ext[EXT_W-1:32]) * (HI_W+32)'(scale);
		end
		if (en[2]) begin
			neg_s7 <= neg_s6;
			big_s7 <= |hi_s6[HI_W+31:32];
			r_s7   <= R_W'((lo_s6 + 64'h8000) >> 16) + R_W'({hi_s6[31:0], 16'd0});
		end
		if (en[3]) begin
			deriv_s8 <= neg_s7 ? OUT_W'(-clip) : clip[OUT_W-1:0];
		end
	end

	assign deriv = deriv_s8;

endmodule

// ===== design/backward_difference_differentiator.sv =====
// top level of the backward finite-difference differentiator
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//  s         in         s_tvalid/s_tready    s_tdata: sample
//  m         out        m_tvalid/m_tready    m_tdata: derivative, m_tuser: window_full
//
// one sample per cycle sustained while m_tready stays high; m_tvalid rises once the sample
// has passed the eight register stages: one in the cell multipliers, three in the adder tree,
// four in scaling and saturation
// arst_n clears the cell history, the fill count and every stage valid;
// registers return to derivative order 1, error order 1, scale 1.0
// a stage holds only behind a held successor, bubbles close up, input stalls when all full
module backward_difference_differentiator import bdd_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	// sample stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
	// derivative stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [OUT_W-1:0]                    m_tdata,  // derivative
	output logic                                m_tuser   // window_full
);

	localparam int PROD_W = SAMPLE_BITS + COEF_W;
	localparam int SUM_W  = SAMPLE_BITS + SUM_GROW;
	localparam int STAGES = 8;

	// configuration, kept zero-based and already clamped
	logic [1:0]         d_q;
	logic [2:0]         e_q;
	logic [SCALE_W-1:0] scale_q;
	logic [2:0]         wr_val;

	logic [3:0]         fill_q;
	logic [STAGES:1]    vld_q;
	logic [STAGES:1]    full_q;
	logic [STAGES:1]    rdy;
	logic               in_xfer;
	logic               full_now;
	logic [4:0]         points;

	logic signed [SAMPLE_BITS-1:0] x [MAX_POINTS];
	logic signed [PROD_W-1:0]      prod [MAX_POINTS];
	logic signed [SUM_W-1:0]       sum;
	logic [OUT_W-1:0]              deriv;

	assign cfg_ready = 1'b1;
	assign wr_val    = cfg_data[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q     <= '0;
			e_q     <= '0;
			scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DERIV_ORDER: begin
					// zero reads as first order, five and up as fourth
					if (wr_val == 3'd0) begin
						d_q <= 2'd0;
					end else if (wr_val > 3'd4) begin
						d_q <= 2'd3;
					end else begin
						d_q <= 2'(wr_val - 3'd1);
					end
				end
				REG_ERROR_ORDER: begin
					if (wr_val == 3'd0) begin
						e_q <= 3'd0;
					end else if (wr_val == 3'd7) begin
						e_q <= 3'd5;
					end else begin
						e_q <= wr_val - 3'd1;
					end
				end
				REG_OUTPUT_SCALE: begin
					scale_q <= cfg_data[SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ready ripples back from the output: a stage moves when empty or when its
	// successor moves
	always_comb begin
		rdy[STAGES] = !vld_q[STAGES] || m_tready;
		for (int i = STAGES - 1; i >= 1; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign s_tready = rdy[1];
	assign in_xfer  = s_tvalid && s_tready;

	// stencil spans d+e+2 points; the current sample counts toward the fill
	assign points   = 5'(d_q) + 5'(e_q) + 5'd2;
	assign full_now = (5'(fill_q) + 5'd1) >= points;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			fill_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_xfer;
			end
			for (int i = 2; i <= STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
			if (in_xfer && (fill_q < 4'(HIST_DEPTH))) begin
				fill_q <= fill_q + 4'd1;
			end
		end
	end

	// window flag rides alongside the data
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			full_q[1] <= full_now;
		end
		for (int i = 2; i <= STAGES; i++) begin
			if (rdy[i]) begin
				full_q[i] <= full_q[i-1];
			end
		end
	end

	// row of cells: each passes its sample to the next on every input transfer
	assign x[0] = s_tdata[SAMPLE_BITS-1:0];

	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		if (k < MAX_POINTS - 1) begin : g_mid
			bdd_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(in_xfer),
				.load_en (rdy[1]),
				.coef    (bdd_coef(d_q, e_q, 4'(k))),
				.x_in    (x[k]),
				.x_out   (x[k+1]),
				.prod    (prod[k])
			);
		end else begin : g_last
			// oldest sample only feeds its product
			bdd_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(in_xfer),
				.load_en (rdy[1]),
				.coef    (bdd_coef(d_q, e_q, 4'(k))),
				.x_in    (x[k]),
				.x_out   (),
				.prod    (prod[k])
			);
		end
	end

	bdd_sum #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_sum (
		.clk (clk),
		.en  (rdy[4:2]),
		.prod(prod),
		.sum (sum)
	);

	bdd_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk  (clk),
		.en   (rdy[8:5]),
		.sum  (sum),
		.scale(scale_q),
		.deriv(deriv)
	);

	assign m_tvalid = vld_q[STAGES];
	assign m_tdata  = deriv;
	assign m_tuser  = full_q[STAGES];

	// an empty output stage must never block the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	// every sample transfer lands in the first stage
	a_first_stage_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> vld_q[1])
		else $error("sample transfer lost at first stage");

	// fill count saturates at the history depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 4'(HIST_DEPTH))
		else $error("fill count beyond history depth");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (fill_q < 4'(HIST_DEPTH))) |=> (fill_q == $past(fill_q) + 4'd1))
		else $error("fill count missed a sample");

	// clamped error order stays inside the table
	a_error_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		e_q <= 3'd5)
		else $error("error order outside stencil table");

endmodule

// ===== bench/backward_difference_differentiator_tb.sv =====
// self-checking testbench for the backward finite-difference differentiator
module backward_difference_differentiator_tb;
	import bdd_pkg::*;

	localparam int SAMPLE_BITS   = 24;
	localparam int TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int HOLD_CYCLES   = 200;     // long receiver hold-off, fills the pipeline
	localparam int DRAIN_CYCLES  = 20;      // quiet time after the last result, covers latency
	localparam int CYCLE_LIMIT   = 500000;

	localparam int SAMPLE_MAX = 8388607;
	localparam int SAMPLE_MIN = -8388608;

	// index with no register behind it, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	// saturation limits of the 48-bit estimate, as magnitudes and as codes
	localparam logic [127:0] POS_MAG = 128'h7FFF_FFFF_FFFF;
	localparam logic [127:0] NEG_MAG = 128'h8000_0000_0000;
	localparam logic [OUT_W-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [OUT_W-1:0] SAT_NEG = 48'h8000_0000_0000;

	// backward stencil weights, [derivative-1][error order-1][tap], tap 0 is the newest sample
	localparam int STENCIL_WEIGHTS [4][6][MAX_POINTS] = '{
		'{
			'{1, -1, 0, 0, 0, 0, 0, 0, 0, 0},
			'{3, -4, 1, 0, 0, 0, 0, 0, 0, 0},
			'{11, -18, 9, -2, 0, 0, 0, 0, 0, 0},
			'{25, -48, 36, -16, 3, 0, 0, 0, 0, 0},
			'{137, -300, 300, -200, 75, -12, 0, 0, 0, 0},
			'{147, -360, 450, -400, 225, -72, 10, 0, 0, 0}
		},
		'{
			'{1, -2, 1, 0, 0, 0, 0, 0, 0, 0},
			'{2, -5, 4, -1, 0, 0, 0, 0, 0, 0},
			'{35, -104, 114, -56, 11, 0, 0, 0, 0, 0},
			'{45, -154, 214, -156, 61, -10, 0, 0, 0, 0},
			'{812, -3132, 5265, -5080, 2970, -972, 137, 0, 0, 0},
			'{938, -4014, 7911, -9490, 7380, -3618, 1019, -126, 0, 0}
		},
		'{
			'{1, -3, 3, -1, 0, 0, 0, 0, 0, 0},
			'{5, -18, 24, -14, 3, 0, 0, 0, 0, 0},
			'{17, -71, 118, -98, 41, -7, 0, 0, 0, 0},
			'{49, -232, 461, -496, 307, -104, 15, 0, 0, 0},
			'{967, -5104, 11787, -15560, 12725, -6432, 1849, -232, 0, 0},
			'{2403, -13960, 36706, -57384, 58280, -39128, 16830, -4216, 469, 0}
		},
		'{
			'{1, -4, 6, -4, 1, 0, 0, 0, 0, 0},
			'{3, -14, 26, -24, 11, -2, 0, 0, 0, 0},
			'{35, -186, 411, -484, 321, -114, 17, 0, 0, 0},
			'{56, -333, 852, -1219, 1056, -555, 164, -21, 0, 0},
			'{3207, -21056, 61156, -102912, 109930, -76352, 33636, -8576, 967, 0},
			'{4275, -30668, 99604, -192624, 244498, -210920, 123348, -47024, 10579, -1068}
		}
	};

	typedef struct packed {
		logic [OUT_W-1:0] derivative;
		logic             window_full;
	} estimate_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_index;        // write rows only
		logic [CFG_DATA_W-1:0]  value;            // register data, or the sample in the low bits
		logic                   typed;            // expected result given in the row
		logic [OUT_W-1:0]       want_derivative;
		logic                   want_full;
	} row_t;

	typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_SWING} signal_style_t;

	// directed stimulus: reset state, sample extremes, saturation both ways, zero scale,
	// out-of-range order writes, the unmapped index, rounding ties at half scale
	localparam int NUM_ROWS = 33;
	localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// order 1 / error 1, unity scale, history still empty
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'h0, 1'b1, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MAX), 1'b1, 48'h7F_FFFF, 1'b1},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MIN), 1'b1, 48'hFFFF_FF00_0001, 1'b1},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MAX), 1'b1, 48'hFF_FFFF, 1'b1},
		// widest stencil at full scale: alternating extremes push every tap the same way
		'{ROW_WRITE, REG_DERIV_ORDER, 32'd4, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_ERROR_ORDER, 32'd6, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_OUTPUT_SCALE, 32'hFFFF_FFFF, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MIN), 1'b1, SAT_NEG, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MAX), 1'b1, SAT_POS, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MIN), 1'b1, SAT_NEG, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MAX), 1'b1, SAT_POS, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MIN), 1'b1, SAT_NEG, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MAX), 1'b1, SAT_POS, 1'b1},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'(SAMPLE_MIN), 1'b1, SAT_NEG, 1'b1},
		// zero scale kills any sum
		'{ROW_WRITE, REG_OUTPUT_SCALE, 32'h0, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'h0012_3456, 1'b1, 48'h0, 1'b1},
		// dropped write, then orders out of range get clamped (0 -> 1, 7 -> 6)
		'{ROW_WRITE, REG_UNMAPPED, 32'h1234_5678, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_DERIV_ORDER, 32'hFFFF_FFF8, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_ERROR_ORDER, 32'h0000_0007, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_OUTPUT_SCALE, 32'h0001_0000, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'h0000_0ABC, 1'b0, 48'h0, 1'b0},
		// derivative 5 -> 4, error 0 -> 1, half scale so odd sums land on a tie
		'{ROW_WRITE, REG_DERIV_ORDER, 32'd5, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_ERROR_ORDER, 32'd0, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_OUTPUT_SCALE, 32'h0000_8000, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'd1, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'hFFFF_FFFF, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'd3, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'hFFFF_FFFD, 1'b0, 48'h0, 1'b0},
		// mid-range orders at scale 1.5
		'{ROW_WRITE, REG_DERIV_ORDER, 32'd2, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_ERROR_ORDER, 32'd3, 1'b0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_OUTPUT_SCALE, 32'h0001_8000, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'd7, 1'b0, 48'h0, 1'b0},
		'{ROW_SAMPLE, REG_DERIV_ORDER, 32'hFFFF_FFF9, 1'b0, 48'h0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;    // sample
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;           // derivative
	logic m_tuser;                       // window_full

	// shadow of the block's registers and history, updated as transfers happen
	logic [2:0] deriv_order = 3'd1;
	logic [2:0] err_order = 3'd1;
	logic [SCALE_W-1:0] out_scale = SCALE_RESET;
	logic signed [SAMPLE_BITS-1:0] sample_history [HIST_DEPTH] = '{default: '0};
	int fill_count = 0;

	estimate_t pending_estimates [$];    // oldest first
	int error_count = 0;
	int cycle_count = 0;

	// idling controls shared between the stimulus and the result sink
	bit tx_gaps = 1'b1;
	bit rx_calm = 1'b0;
	bit rx_hold_request = 1'b0;

	backward_difference_differentiator #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
			: int'($urandom_range(1, 3));
	endfunction

	// stop offering samples and wait until every predicted result has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_estimates.size() != 0) @(posedge clk);
	endtask

	// register write, only ever issued with the pipeline empty
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		// orders are taken from the low three bits and clamped into range
		case (idx)
			REG_DERIV_ORDER: begin
				deriv_order = (data[2:0] == 3'd0) ? 3'd1 : (data[2:0] > 3'd4) ? 3'd4 : data[2:0];
			end
			REG_ERROR_ORDER: begin
				err_order = (data[2:0] == 3'd0) ? 3'd1 : (data[2:0] > 3'd6) ? 3'd6 : data[2:0];
			end
			REG_OUTPUT_SCALE: begin
				out_scale = data;
			end
			default: ;
		endcase
	endtask

	// offer one sample; on its transfer work out the derivative estimate and shift history
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic typed,
		input estimate_t typed_est);
		estimate_t est;
		longint acc;
		logic [63:0] mag;
		logic [127:0] rounded;
		int d;
		int e;
		s_tvalid <= 1'b1;
		s_tdata <= TDATA_W'(smp);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		d = int'(deriv_order) - 1;
		e = int'(err_order) - 1;
		// weighted sum over the newest sample and the nine-deep history, empty slots are zero
		acc = longint'(STENCIL_WEIGHTS[d][e][0]) * longint'($signed(smp));
		for (int k = 1; k < MAX_POINTS; k++)
			acc += longint'(STENCIL_WEIGHTS[d][e][k]) * longint'(sample_history[k-1]);
		// Q16.16 scale on the magnitude, round half away from zero, then clamp
		mag = (acc < 0) ? 64'(-acc) : 64'(acc);
		rounded = (128'(mag) * 128'(out_scale) + 128'h8000) >> 16;
		if (acc < 0) begin
			if (rounded > NEG_MAG) rounded = NEG_MAG;
			est.derivative = 48'd0 - rounded[OUT_W-1:0];
		end else begin
			if (rounded > POS_MAG) rounded = POS_MAG;
			est.derivative = rounded[OUT_W-1:0];
		end
		// enough samples for derivative+error points, counting this one
		est.window_full = (fill_count + 1 >= d + e + 2);
		for (int k = HIST_DEPTH - 1; k > 0; k--)
			sample_history[k] = sample_history[k-1];
		sample_history[0] = $signed(smp);
		if (fill_count < HIST_DEPTH) fill_count++;
		pending_estimates.push_back(typed ? typed_est : est);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_length()) @(posedge clk);
		end
	endtask

	// result sink: random back-pressure, or one long hold-off when asked for
	initial begin : result_sink
		int stall_len;
		forever begin
			@(posedge clk);
			if (rx_hold_request) begin
				rx_hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				stall_len = gap_length();
				repeat (stall_len) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare every result transfer with the oldest outstanding estimate
	always @(posedge clk) begin : result_check
		estimate_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_estimates.size() == 0) begin
				$display("%0t: result with nothing expected, derivative %h window_full %b",
					$time, m_tdata, m_tuser);
				error_count++;
			end else begin
				want = pending_estimates.pop_front();
				if (m_tdata !== want.derivative) begin
					$display("%0t: derivative mismatch, expected %h, got %h",
						$time, want.derivative, m_tdata);
					error_count++;
				end
				if (m_tuser !== want.window_full) begin
					$display("%0t: window_full mismatch, expected %b, got %b",
						$time, want.window_full, m_tuser);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		row_t row;
		signal_style_t style;
		logic [2:0] d_pick;
		logic [2:0] e_pick;
		logic [SCALE_W-1:0] scale_pick;
		logic [SAMPLE_BITS-1:0] smp;
		int random_items;
		int phase;
		int item_count;
		int poly_c0;
		int poly_c1;
		int poly_c2;
		int poly_c3;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, walked row by row
		for (int r = 0; r < NUM_ROWS; r++) begin
			row = DIRECTED_ROWS[r];
			if (row.kind == ROW_WRITE)
				write_register(row.reg_index, row.value);
			else
				send_sample(row.value[SAMPLE_BITS-1:0], row.typed,
					{row.want_derivative, row.want_full});
		end

		// random part, one register setting per phase
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (phase)
				0: begin
					d_pick = 3'd1;
					e_pick = 3'd1;
					scale_pick = SCALE_RESET;
				end
				1: begin
					d_pick = 3'd4;
					e_pick = 3'd6;
					scale_pick = '1;
				end
				2: begin
					d_pick = 3'd1;
					e_pick = 3'd6;
					scale_pick = 32'd1;
				end
				default: begin
					d_pick = 3'($urandom_range(0, 7));
					e_pick = 3'($urandom_range(0, 7));
					case ($urandom_range(0, 6))
						0: scale_pick = SCALE_RESET;
						1: scale_pick = '0;
						2: scale_pick = '1;
						3: scale_pick = $urandom_range(1, 1024);
						4: scale_pick = 32'h0000_8000;
						default: scale_pick = $urandom();
					endcase
				end
			endcase
			// upper data bits are don't-care for the order registers
			write_register(REG_DERIV_ORDER, {29'($urandom()), d_pick});
			write_register(REG_ERROR_ORDER, {29'($urandom()), e_pick});
			write_register(REG_OUTPUT_SCALE, scale_pick);
			if ($urandom_range(0, 4) == 0)
				write_register(REG_UNMAPPED, $urandom());

			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			// one phase runs the sender flat out against a long receiver hold-off
			if (phase == 3) begin
				tx_gaps = 1'b0;
				rx_calm = 1'b1;
				rx_hold_request = 1'b1;
			end

			style = signal_style_t'($urandom_range(0, 2));
			poly_c0 = int'($urandom_range(0, 8000000)) - 4000000;
			poly_c1 = int'($urandom_range(0, 4000)) - 2000;
			poly_c2 = int'($urandom_range(0, 120)) - 60;
			poly_c3 = int'($urandom_range(0, 6)) - 3;
			item_count = (phase == 3) ? 80 : int'($urandom_range(10, 100));

			for (int i = 0; i < item_count; i++) begin
				// now and then let the pipeline run dry mid-phase
				if (phase % 4 == 2 && i == item_count / 2)
					wait_idle();
				case (style)
					STYLE_SMOOTH: begin
						// cubic trend with a little noise, wraps at the sample width
						smp = SAMPLE_BITS'(poly_c0 + poly_c1 * i + poly_c2 * i * i
							+ poly_c3 * i * i * i + int'($urandom_range(0, 6)) - 3);
					end
					STYLE_SWING: begin
						// near-extreme alternation drives the scale into saturation
						smp = (i % 2 != 0)
							? SAMPLE_BITS'(SAMPLE_MAX - int'($urandom_range(0, 255)))
							: SAMPLE_BITS'(SAMPLE_MIN + int'($urandom_range(0, 255)));
					end
					default: begin
						case ($urandom_range(0, 7))
							0: begin
								case ($urandom_range(0, 3))
									0: smp = SAMPLE_BITS'(SAMPLE_MAX);
									1: smp = SAMPLE_BITS'(SAMPLE_MIN);
									2: smp = '0;
									default: smp = '1;
								endcase
							end
							1, 2: smp = SAMPLE_BITS'(int'($urandom_range(0, 200)) - 100);
							default: smp = SAMPLE_BITS'($urandom());
						endcase
					end
				endcase
				send_sample(smp, 1'b0, '0);
			end
			random_items += item_count;
			phase++;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
